>>> rtl/gbt_pkg.sv
// Shared types and constants for the graph traversal block.
// No dependencies; every other file refers to it by scoped names.
package gbt_pkg;

	// Sizes of the vertex set and the work store
	localparam int MAX_VERTICES = 16;
	localparam int WORK_DEPTH   = 256;

	// Derived widths
	localparam int VW     = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int REG_W  = 5;
	localparam int CMP_W  = (CNT_W > REG_W) ? CNT_W : REG_W;
	localparam int AW     = $clog2(WORK_DEPTH);
	localparam int WCNT_W = AW + 1;

	// Payload widths of the channels
	localparam int CMD_W  = 2;
	localparam int VTX_W  = 4;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_VERTEX_COUNT = 1'b0;
	localparam logic [REG_W-1:0] VERTEX_COUNT_RST = REG_W'(16);

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR    = 2'd0,
		CMD_ADD_EDGE = 2'd1,
		CMD_TRAVERSE = 2'd2
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_POP,
		ST_CHECK,
		ST_EMIT,
		ST_SCAN,
		ST_NEXT,
		ST_FINISH,
		ST_ERR
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear;
		logic add_edge;
		logic start;
		logic pop;
		logic mark;
		logic scan;
		logic emit_pend;
		logic emit_final;
		logic emit_err;
	} gbt_ctl_t;

	// Datapath to controller status
	typedef struct packed {
		logic bad_edge;
		logic bad_start;
		logic visited_hit;
		logic count_zero;
		logic scan_last;
		logic out_free;
		logic pend_valid;
	} gbt_stat_t;

endpackage

>>> rtl/gbt_if.sv
// Valid/ready channel interfaces for command requests and traversal results.
// Depends on gbt_pkg for payload widths.
interface gbt_req_if;
	logic                        valid;
	logic                        ready;
	logic [gbt_pkg::CMD_W-1:0]   cmd;
	logic [gbt_pkg::VTX_W-1:0]   vertex_a;
	logic [gbt_pkg::VTX_W-1:0]   vertex_b;
	logic                        depth_first;

	modport source (output valid, cmd, vertex_a, vertex_b, depth_first, input ready);
	modport sink   (input valid, cmd, vertex_a, vertex_b, depth_first, output ready);
endinterface

interface gbt_res_if;
	logic                        valid;
	logic                        ready;
	logic [gbt_pkg::VTX_W-1:0]   visited_vertex;
	logic                        last;
	logic                        error;

	modport source (output valid, visited_vertex, last, error, input ready);
	modport sink   (input valid, visited_vertex, last, error, output ready);
endinterface

>>> rtl/gbt_ctrl.sv
// Traversal sequencer: decodes requests and steps the datapath through
// pop, check, emit and neighbor scan. Depends on gbt_pkg.
module gbt_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  gbt_pkg::cmd_code_t  in_cmd,
	output logic                in_ready,
	input  gbt_pkg::gbt_stat_t  stat,
	output gbt_pkg::gbt_ctl_t   ctl
);

	gbt_pkg::state_t state_q, state_d;

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbt_pkg::ST_IDLE: begin
				if (in_valid) begin
					case (in_cmd)
						gbt_pkg::CMD_ADD_EDGE: begin
							if (stat.bad_edge) state_d = gbt_pkg::ST_ERR;
						end
						gbt_pkg::CMD_TRAVERSE: begin
							state_d = stat.bad_start ? gbt_pkg::ST_ERR : gbt_pkg::ST_POP;
						end
						default: state_d = gbt_pkg::ST_IDLE;
					endcase
				end
			end
			gbt_pkg::ST_POP: state_d = gbt_pkg::ST_CHECK;
			gbt_pkg::ST_CHECK: begin
				if (!stat.visited_hit) state_d = gbt_pkg::ST_EMIT;
				else if (stat.count_zero) state_d = gbt_pkg::ST_FINISH;
				else state_d = gbt_pkg::ST_POP;
			end
			gbt_pkg::ST_EMIT: begin
				if (!stat.pend_valid || stat.out_free) state_d = gbt_pkg::ST_SCAN;
			end
			gbt_pkg::ST_SCAN: begin
				if (stat.scan_last) state_d = gbt_pkg::ST_NEXT;
			end
			gbt_pkg::ST_NEXT: begin
				state_d = stat.count_zero ? gbt_pkg::ST_FINISH : gbt_pkg::ST_POP;
			end
			gbt_pkg::ST_FINISH: begin
				if (!stat.pend_valid || stat.out_free) state_d = gbt_pkg::ST_IDLE;
			end
			gbt_pkg::ST_ERR: begin
				if (stat.out_free) state_d = gbt_pkg::ST_IDLE;
			end
			default: state_d = gbt_pkg::ST_IDLE;
		endcase
	end

	// Drive commands
	always_comb begin
		ctl      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			gbt_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (in_cmd)
						gbt_pkg::CMD_CLEAR:    ctl.clear    = 1'b1;
						gbt_pkg::CMD_ADD_EDGE: ctl.add_edge = !stat.bad_edge;
						gbt_pkg::CMD_TRAVERSE: ctl.start    = !stat.bad_start;
						default: ctl = '0;
					endcase
				end
			end
			gbt_pkg::ST_POP:   ctl.pop  = 1'b1;
			gbt_pkg::ST_CHECK: ctl.mark = !stat.visited_hit;
			gbt_pkg::ST_EMIT:  ctl.emit_pend = !stat.pend_valid || stat.out_free;
			gbt_pkg::ST_SCAN:  ctl.scan = 1'b1;
			gbt_pkg::ST_NEXT:  ctl = '0;
			gbt_pkg::ST_FINISH: ctl.emit_final = stat.pend_valid && stat.out_free;
			gbt_pkg::ST_ERR:   ctl.emit_err = stat.out_free;
			default: ctl = '0;
		endcase
	end

endmodule

>>> rtl/gbt_datapath.sv
// Adjacency matrix, visited map, work store with its pointers, the pending
// result and the output register. Depends on gbt_pkg and gbt_if.
module gbt_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [gbt_pkg::VTX_W-1:0]          vertex_a,
	input  logic [gbt_pkg::VTX_W-1:0]          vertex_b,
	input  logic                               depth_first,
	input  logic [gbt_pkg::REG_W-1:0]          vertex_count,
	input  gbt_pkg::gbt_ctl_t                  ctl,
	output gbt_pkg::gbt_stat_t                 stat,
	gbt_res_if.source                          res
);

	localparam int VW  = gbt_pkg::VW;
	localparam int AW  = gbt_pkg::AW;
	localparam int NV  = gbt_pkg::MAX_VERTICES;
	localparam int CW  = gbt_pkg::CMP_W;
	localparam int WCW = gbt_pkg::WCNT_W;

	logic [NV-1:0]  adj_q [NV];
	logic [NV-1:0]  visited_q;
	logic [VW-1:0]  work_mem [gbt_pkg::WORK_DEPTH];
	logic [VW-1:0]  rd_data_q;
	logic [AW-1:0]  head_q, tail_q;
	logic [WCW-1:0] count_q;
	logic           lifo_q;
	logic [VW-1:0]  cur_q;
	logic [VW-1:0]  scan_q;
	logic [VW-1:0]  pend_q;
	logic           pend_valid_q;
	logic           out_valid_q;
	logic [gbt_pkg::VTX_W-1:0] out_vertex_q;
	logic           out_last_q;
	logic           out_err_q;

	logic [CW-1:0]  eff_cnt;
	logic [VW-1:0]  a_idx, b_idx;
	logic [AW-1:0]  tail_dec, tail_inc, head_inc;
	logic           push_ok;
	logic           mem_wr;
	logic [AW-1:0]  mem_wr_addr;
	logic [VW-1:0]  mem_wr_data;
	logic [AW-1:0]  mem_rd_addr;
	logic           out_free;

	// Saturate the vertex count and take the request's vertex indices
	always_comb begin
		eff_cnt = (CW'(vertex_count) > CW'(NV)) ? CW'(NV) : CW'(vertex_count);
		a_idx   = VW'(vertex_a);
		b_idx   = VW'(vertex_b);
	end

	// Wrap the work store pointers
	always_comb begin
		tail_dec = (tail_q == '0) ? AW'(gbt_pkg::WORK_DEPTH - 1) : tail_q - AW'(1);
		tail_inc = (tail_q == AW'(gbt_pkg::WORK_DEPTH - 1)) ? '0 : tail_q + AW'(1);
		head_inc = (head_q == AW'(gbt_pkg::WORK_DEPTH - 1)) ? '0 : head_q + AW'(1);
	end

	// Push a neighbor that is linked and not yet visited, unless the store is full
	assign push_ok = adj_q[cur_q][scan_q] && !visited_q[scan_q]
		&& (count_q != WCW'(gbt_pkg::WORK_DEPTH));

	assign mem_wr      = ctl.start || (ctl.scan && push_ok);
	assign mem_wr_addr = ctl.start ? '0 : tail_q;
	assign mem_wr_data = ctl.start ? a_idx : scan_q;
	assign mem_rd_addr = lifo_q ? tail_dec : head_q;

	assign out_free = !out_valid_q || res.ready;

	// Report status
	always_comb begin
		stat.bad_edge    = (CW'(vertex_a) >= eff_cnt) || (CW'(vertex_b) >= eff_cnt);
		stat.bad_start   = (CW'(vertex_a) >= eff_cnt);
		stat.visited_hit = visited_q[rd_data_q];
		stat.count_zero  = (count_q == '0);
		stat.scan_last   = (CW'(scan_q) == eff_cnt - CW'(1));
		stat.out_free    = out_free;
		stat.pend_valid  = pend_valid_q;
	end

	// Update the adjacency matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NV; i++) adj_q[i] <= '0;
		end else if (ctl.clear) begin
			for (int i = 0; i < NV; i++) adj_q[i] <= '0;
		end else if (ctl.add_edge && (vertex_a != vertex_b)) begin
			adj_q[a_idx][b_idx] <= 1'b1;
			adj_q[b_idx][a_idx] <= 1'b1;
		end
	end

	// Work store
	always_ff @(posedge clk) begin
		if (mem_wr) work_mem[mem_wr_addr] <= mem_wr_data;
		if (ctl.pop) rd_data_q <= work_mem[mem_rd_addr];
	end

	// Pointers, count and visited map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			count_q   <= '0;
			visited_q <= '0;
			scan_q    <= '0;
			cur_q     <= '0;
		end else begin
			if (ctl.start) begin
				head_q    <= '0;
				tail_q    <= AW'(1);
				count_q   <= WCW'(1);
				visited_q <= '0;
			end else if (ctl.pop) begin
				if (lifo_q) tail_q <= tail_dec;
				else head_q <= head_inc;
				count_q <= count_q - WCW'(1);
			end else if (ctl.scan) begin
				if (push_ok) begin
					tail_q  <= tail_inc;
					count_q <= count_q + WCW'(1);
				end
				scan_q <= scan_q + VW'(1);
			end
			if (ctl.mark) begin
				visited_q[rd_data_q] <= 1'b1;
				cur_q  <= rd_data_q;
				scan_q <= '0;
			end
		end
	end

	// Latch traversal order
	always_ff @(posedge clk) begin
		if (ctl.start) lifo_q <= depth_first;
	end

	// Hold the newest visited vertex until the next one shows it is not the last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (ctl.start) begin
			pend_valid_q <= 1'b0;
		end else if (ctl.emit_pend) begin
			pend_valid_q <= 1'b1;
		end else if (ctl.emit_final) begin
			pend_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_pend) pend_q <= cur_q;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.emit_err || ctl.emit_final || (ctl.emit_pend && pend_valid_q)) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_err) begin
			out_vertex_q <= '0;
			out_last_q   <= 1'b1;
			out_err_q    <= 1'b1;
		end else if (ctl.emit_final || (ctl.emit_pend && pend_valid_q)) begin
			out_vertex_q <= gbt_pkg::VTX_W'(pend_q);
			out_last_q   <= ctl.emit_final;
			out_err_q    <= 1'b0;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.visited_vertex = out_vertex_q;
	assign res.last           = out_last_q;
	assign res.error          = out_err_q;

endmodule

>>> rtl/graph_bfs_dfs_traversal.sv
// Top level of the graph traversal block: configuration register, sequencer
// and datapath. Depends on gbt_pkg, gbt_if, gbt_ctrl and gbt_datapath.
//
//   channel  dir  handshake              payload
//   req      in   valid/ready            cmd, vertex_a, vertex_b, depth_first
//   res      out  valid/ready            visited_vertex, last, error
//   apb      in   psel/penable, pready=1 vertex_count at address 0
//
// Clear and add-edge are done as the request is accepted; a bad request goes on
// to an error result. During a traversal the neighbor scan visits one matrix
// column per cycle, up to the vertex count N, and each pop waits on the
// registered read of the work store.
// Reset is asynchronous and empties the graph; the work store needs no clearing.
// A stalled result stalls the sequencer once the pending vertex must move out.
module graph_bfs_dfs_traversal (
	input  logic                          clk,
	input  logic                          arst_n,
	gbt_req_if.sink                       req,
	gbt_res_if.source                     res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [gbt_pkg::PADDR_W-1:0]   paddr,
	input  logic [gbt_pkg::PDATA_W-1:0]   pwdata,
	output logic [gbt_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	logic [gbt_pkg::REG_W-1:0] vertex_count_q;
	gbt_pkg::gbt_ctl_t         ctl;
	gbt_pkg::gbt_stat_t        stat;
	logic                      reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == gbt_pkg::REG_VERTEX_COUNT);

	// Write the vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= gbt_pkg::VERTEX_COUNT_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			vertex_count_q <= pwdata[gbt_pkg::REG_W-1:0];
		end
	end

	// Read back
	assign prdata = reg_sel ? gbt_pkg::PDATA_W'(vertex_count_q) : '0;

	gbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_cmd   (gbt_pkg::cmd_code_t'(req.cmd)),
		.in_ready (req.ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	gbt_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.vertex_a     (req.vertex_a),
		.vertex_b     (req.vertex_b),
		.depth_first  (req.depth_first),
		.vertex_count (vertex_count_q),
		.ctl          (ctl),
		.stat         (stat),
		.res          (res)
	);

endmodule
